// File: sv/assert_macros.svh
// assertion helpers shared by the timecode converter rtl
// no dependencies; take in with `include "assert_macros.svh"
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/tfc_pkg.sv
// shared types, constants and helpers of the timecode / frame-count converter
// used by tfc_front, tfc_div_pipe users and the top level; no dependencies
`default_nettype none

package tfc_pkg;

    localparam int unsigned COUNT_W = 26;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [5:0] SEC_PER_MIN  = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;

    // smallest rate at which round(rate*6/100) reaches 1, 2, ... 8
    localparam logic [6:0] DROP_STEP [8] = '{7'd9, 7'd25, 7'd42, 7'd59,
                                             7'd75, 7'd92, 7'd109, 7'd125};

    // frames dropped per minute, round(rate*6/100)
    function automatic logic [3:0] drop_per_min(input logic [6:0] rate);
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            if (rate >= DROP_STEP[k]) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

    // front end result, travels with the request into the divider chain
    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] fc;
        logic [3:0]         drop;
        logic [16:0]        per10;
        logic [12:0]        permin;
        logic [COUNT_W-1:0] fcres;
    } front_t;

    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] fcres;
    } base_t;

    typedef struct packed {
        base_t              base;
        logic [COUNT_W-1:0] fc;
        logic [3:0]         drop;
        logic [12:0]        permin;
    } side_a_t;

    typedef struct packed {
        base_t       base;
        logic [3:0]  drop;
        logic [26:0] fc1;
    } side_b_t;

    typedef struct packed {
        base_t      base;
        logic [6:0] frames;
    } side_d_t;

    typedef struct packed {
        side_d_t    d;
        logic [5:0] seconds;
    } side_e_t;

    typedef struct packed {
        side_e_t    e;
        logic [5:0] minutes;
    } side_f_t;

endpackage

`default_nettype wire

// File: sv/tfc_div_pipe.sv
// pipelined restoring divider, one quotient bit per register stage
// carries a sideband word alongside; no package dependencies
`default_nettype none

module tfc_div_pipe #(
    parameter int unsigned NUM_W  = 8,
    parameter int unsigned DEN_W  = 8,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quo,
    output logic [DEN_W-1:0]       out_rem,
    output logic [SIDE_W-1:0]      out_side
);

    logic [NUM_W-1:0]  v_reg;
    logic [NUM_W-1:0]  nq_reg   [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    logic [NUM_W-1:0]  nq_prev  [NUM_W];
    logic [DEN_W-1:0]  rem_prev [NUM_W];
    logic [DEN_W-1:0]  den_prev [NUM_W];
    logic [NUM_W-1:0]  nq_next  [NUM_W];
    logic [DEN_W-1:0]  rem_next [NUM_W];
    logic [DEN_W:0]    trial    [NUM_W];
    logic [NUM_W-1:0]  fits;

    always_comb begin
        nq_prev[0]  = in_num;
        rem_prev[0] = '0;
        den_prev[0] = in_den;
        for (int i = 1; i < NUM_W; i++) begin
            nq_prev[i]  = nq_reg[i-1];
            rem_prev[i] = rem_reg[i-1];
            den_prev[i] = den_reg[i-1];
        end
        for (int i = 0; i < NUM_W; i++) begin
            // shift in the next numerator bit, subtract when it fits
            trial[i]    = {rem_prev[i], nq_prev[i][NUM_W-1]};
            fits[i]     = trial[i] >= {1'b0, den_prev[i]};
            nq_next[i]  = {nq_prev[i][NUM_W-2:0], fits[i]};
            rem_next[i] = fits[i] ? DEN_W'(trial[i] - {1'b0, den_prev[i]})
                                  : trial[i][DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_W; i++) begin
                nq_reg[i]  <= nq_next[i];
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_prev[i];
            end
            side_reg[0] <= in_side;
            for (int i = 1; i < NUM_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

// File: sv/tfc_front.sv
// four-stage front end: timecode to frame count, plus drop-frame block sizes
// depends on tfc_pkg
`default_nettype none

module tfc_front import tfc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic               in_kind,
    input  wire logic               in_drop,
    input  wire logic [COUNT_W-1:0] in_fc,
    input  wire logic [6:0]         in_hours,
    input  wire logic [6:0]         in_minutes,
    input  wire logic [6:0]         in_seconds,
    input  wire logic [6:0]         in_frames,
    input  wire logic [6:0]         rate,
    output logic                    out_valid,
    output front_t                  out_data
);

    logic [3:0] v_reg;

    front_t      f1_reg, f2_reg, f3_reg, f4_reg;
    front_t      f1_next, f4_next;
    logic [18:0] sec1_reg, sec1_next;
    logic [12:0] tm1_reg, tm1_next;
    logic [6:0]  fr1_reg;
    logic [12:0] tmq2_reg, tmq2_next;
    logic [26:0] total2_reg, total2_next, total3_reg;
    logic [25:0] tq_prod;
    logic [16:0] sub3_reg, sub3_next;
    logic [26:0] diff;
    logic [3:0]  drop_next;

    always_comb begin
        drop_next       = in_drop ? drop_per_min(rate) : 4'd0;
        sec1_next       = 19'(in_hours) * 19'd3600 + 19'(in_minutes) * 19'd60
                        + 19'(in_seconds);
        tm1_next        = 13'(in_hours) * 13'd60 + 13'(in_minutes);
        f1_next.kind    = in_kind;
        f1_next.fc      = in_fc;
        f1_next.drop    = drop_next;
        f1_next.per10   = 17'(rate) * 17'd600 - 17'(drop_next) * 17'd9;
        f1_next.permin  = 13'(rate) * 13'd60 - 13'(drop_next);
        f1_next.fcres   = '0;
    end

    // tm - tm/10, with tm/10 by reciprocal, exact for tm below 8192
    always_comb begin
        tq_prod     = 26'(tm1_reg) * 26'd6554;
        tmq2_next   = tm1_reg - 13'(tq_prod[25:16]);
        total2_next = 27'(sec1_reg) * 27'(rate) + 27'(fr1_reg);
        sub3_next   = 17'(f2_reg.drop) * 17'(tmq2_reg);
    end

    always_comb begin
        diff = (total3_reg > 27'(sub3_reg)) ? total3_reg - 27'(sub3_reg) : '0;
        f4_next = f3_reg;
        f4_next.fcres = (diff > 27'(COUNT_MAX)) ? COUNT_MAX : diff[COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg     <= f1_next;
            sec1_reg   <= sec1_next;
            tm1_reg    <= tm1_next;
            fr1_reg    <= in_frames;
            f2_reg     <= f1_reg;
            tmq2_reg   <= tmq2_next;
            total2_reg <= total2_next;
            f3_reg     <= f2_reg;
            total3_reg <= total2_reg;
            sub3_reg   <= sub3_next;
            f4_reg     <= f4_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = f4_reg;

endmodule

`default_nettype wire

// File: sv/timecode_frame_converter.sv
// top level of the timecode / frame-count converter
// depends on tfc_pkg, tfc_front, tfc_div_pipe and assert_macros.svh
//
//  channel   ports                          direction  moves
//  s_        s_valid/s_ready + 7 fields     in         conversion request
//  m_        m_valid/m_ready + 5 fields     out        conversion result
//  cfg_      cfg_we/cfg_wdata               in         frame rate write
//
// one request per cycle while the output register is free or taken; the stages in order are the
// input register, the front end, dividers by run-time values (ten-minute blocks, minute, rate) with an add
// stage after the first two, six reciprocal stages for /60, /60 and %24, and the output register
// synchronous active-low reset clears all valid bits and sets the rate to 30
// when the output register is full and not taken the whole pipe holds, and
// only an empty input stage may still take a request
`default_nettype none

module timecode_frame_converter import tfc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic               s_drop_frame,
    input  wire logic [COUNT_W-1:0] s_frame_count_in,
    input  wire logic [6:0]         s_hours_in,
    input  wire logic [6:0]         s_minutes_in,
    input  wire logic [6:0]         s_seconds_in,
    input  wire logic [6:0]         s_frames_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COUNT_W-1:0]      m_frame_count_out,
    output logic [4:0]              m_hours_out,
    output logic [5:0]              m_minutes_out,
    output logic [5:0]              m_seconds_out,
    output logic [6:0]              m_frames_out
);

`include "assert_macros.svh"

    // frame rate register
    logic [6:0] rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= 7'd30;
        end else if (cfg_we) begin
            rate_reg <= cfg_wdata;
        end
    end

    // global advance: the pipe moves whenever the output slot frees up
    logic en;
    logic in_v_reg;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en || !in_v_reg;

    // input capture stage
    logic               kind_reg, drop_reg;
    logic [COUNT_W-1:0] fc_reg;
    logic [6:0]         hours_reg, minutes_reg, seconds_reg, frames_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            kind_reg    <= s_kind;
            drop_reg    <= s_drop_frame;
            fc_reg      <= s_frame_count_in;
            hours_reg   <= s_hours_in;
            minutes_reg <= s_minutes_in;
            seconds_reg <= s_seconds_in;
            frames_reg  <= s_frames_in;
        end
    end

    // to-frames result and drop-frame block sizes
    logic   fr_valid;
    front_t fr_data;

    tfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (in_v_reg),
        .in_kind    (kind_reg),
        .in_drop    (drop_reg),
        .in_fc      (fc_reg),
        .in_hours   (hours_reg),
        .in_minutes (minutes_reg),
        .in_seconds (seconds_reg),
        .in_frames  (frames_reg),
        .rate       (rate_reg),
        .out_valid  (fr_valid),
        .out_data   (fr_data)
    );

    // ten-minute blocks: fc / per10
    side_a_t            a_side_in, a_side_out;
    logic               a_valid;
    logic [COUNT_W-1:0] a_quo;
    logic [16:0]        a_rem;

    always_comb begin
        a_side_in.base.kind  = fr_data.kind;
        a_side_in.base.fcres = fr_data.fcres;
        a_side_in.fc         = fr_data.fc;
        a_side_in.drop       = fr_data.drop;
        a_side_in.permin     = fr_data.permin;
    end

    tfc_div_pipe #(.NUM_W(COUNT_W), .DEN_W(17), .SIDE_W($bits(side_a_t))) u_div_block (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_num    (fr_data.fc),
        .in_den    (fr_data.per10),
        .in_side   (a_side_in),
        .out_valid (a_valid),
        .out_quo   (a_quo),
        .out_rem   (a_rem),
        .out_side  (a_side_out)
    );

    // add back nine dropped minutes per block; remainder past the first drop
    logic        x_v_reg;
    side_b_t     x_side_reg, x_side_next;
    logic [16:0] x_num_reg, x_num_next;
    logic [12:0] x_den_reg;
    logic [32:0] blk_add;

    always_comb begin
        blk_add = 33'(a_quo) * 33'(7'(a_side_out.drop) * 7'd9);
        x_side_next.base = a_side_out.base;
        x_side_next.drop = a_side_out.drop;
        x_side_next.fc1  = 27'(a_side_out.fc) + blk_add[26:0];
        x_num_next = (a_rem >= 17'(a_side_out.drop)) ? a_rem - 17'(a_side_out.drop) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_v_reg <= 1'b0;
        end else if (en) begin
            x_v_reg <= a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_side_reg <= x_side_next;
            x_num_reg  <= x_num_next;
            x_den_reg  <= a_side_out.permin;
        end
    end

    // dropped minutes inside the block: (rem - d) / perMin
    side_b_t     b_side_out;
    logic        b_valid;
    logic [16:0] b_quo;
    logic [12:0] b_rem;

    tfc_div_pipe #(.NUM_W(17), .DEN_W(13), .SIDE_W($bits(side_b_t))) u_div_minute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (x_v_reg),
        .in_num    (x_num_reg),
        .in_den    (x_den_reg),
        .in_side   (x_side_reg),
        .out_valid (b_valid),
        .out_quo   (b_quo),
        .out_rem   (b_rem),
        .out_side  (b_side_out)
    );

    // adjusted count after adding the minute drops
    logic        y_v_reg;
    base_t       y_base_reg;
    logic [26:0] y_fc_reg, y_fc_next;
    logic [20:0] min_add;

    always_comb begin
        min_add   = 21'(b_quo) * 21'(b_side_out.drop);
        y_fc_next = b_side_out.fc1 + 27'(min_add);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_v_reg <= 1'b0;
        end else if (en) begin
            y_v_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_base_reg <= b_side_out.base;
            y_fc_reg   <= y_fc_next;
        end
    end

    // split into seconds and frames
    base_t       c_side_out;
    logic        c_valid;
    logic [26:0] c_quo;
    logic [6:0]  c_rem;

    tfc_div_pipe #(.NUM_W(27), .DEN_W(7), .SIDE_W($bits(base_t))) u_div_rate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (y_v_reg),
        .in_num    (y_fc_reg),
        .in_den    (rate_reg),
        .in_side   (y_base_reg),
        .out_valid (c_valid),
        .out_quo   (c_quo),
        .out_rem   (c_rem),
        .out_side  (c_side_out)
    );

    // constant divides by reciprocal multiply: a multiply stage, then a remainder stage
    // seconds stay below 2^27 and minutes below 2^21, so every quotient is exact
    localparam logic [27:0] RECIP_SEC  = 28'd143165577;  // ceil(2^33 / 60)
    localparam logic [21:0] RECIP_MIN  = 22'd2236963;    // ceil(2^27 / 60)
    localparam logic [16:0] RECIP_HOUR = 17'd87382;      // ceil(2^21 / 24)

    logic        s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    side_d_t     s1_side_reg, s1_side_next;
    side_e_t     s2_side_reg, s2_side_next, s3_side_reg;
    side_f_t     s4_side_reg, s4_side_next, s5_side_reg, s6_side_reg;
    logic [26:0] s1_num_reg;
    logic [20:0] s1_quo_reg, s1_quo_next;
    logic [20:0] s2_num_reg, s3_num_reg;
    logic [15:0] s3_quo_reg, s3_quo_next;
    logic [15:0] s4_num_reg, s5_num_reg;
    logic [11:0] s5_quo_reg, s5_quo_next;
    logic [4:0]  s6_hours_reg;
    logic [54:0] sec_prod;
    logic [26:0] sec_left;
    logic [42:0] min_prod;
    logic [20:0] min_left;
    logic [32:0] hour_prod;
    logic [15:0] hour_left;

    always_comb begin
        // seconds / 60
        s1_side_next = '{base: c_side_out, frames: c_rem};
        sec_prod     = 55'(c_quo) * 55'(RECIP_SEC);
        s1_quo_next  = sec_prod[53:33];
        sec_left     = s1_num_reg - 27'(s1_quo_reg) * 27'(SEC_PER_MIN);
        s2_side_next = '{d: s1_side_reg, seconds: sec_left[5:0]};
        // minutes / 60
        min_prod     = 43'(s2_num_reg) * 43'(RECIP_MIN);
        s3_quo_next  = min_prod[42:27];
        min_left     = s3_num_reg - 21'(s3_quo_reg) * 21'(SEC_PER_MIN);
        s4_side_next = '{e: s3_side_reg, minutes: min_left[5:0]};
        // hours % 24
        hour_prod    = 33'(s4_num_reg) * 33'(RECIP_HOUR);
        s5_quo_next  = hour_prod[32:21];
        hour_left    = s5_num_reg - 16'(s5_quo_reg) * 16'(HOURS_PER_DAY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= c_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg  <= s1_side_next;
            s1_num_reg   <= c_quo;
            s1_quo_reg   <= s1_quo_next;
            s2_side_reg  <= s2_side_next;
            s2_num_reg   <= s1_quo_reg;
            s3_side_reg  <= s2_side_reg;
            s3_num_reg   <= s2_num_reg;
            s3_quo_reg   <= s3_quo_next;
            s4_side_reg  <= s4_side_next;
            s4_num_reg   <= s3_quo_reg;
            s5_side_reg  <= s4_side_reg;
            s5_num_reg   <= s4_num_reg;
            s5_quo_reg   <= s5_quo_next;
            s6_side_reg  <= s5_side_reg;
            s6_hours_reg <= hour_left[4:0];
        end
    end

    // output register: pick the direction, zero timecode at rate zero
    logic [COUNT_W-1:0] fc_out_reg, fc_out_next;
    logic [4:0]         hours_out_reg, hours_out_next;
    logic [5:0]         minutes_out_reg, minutes_out_next;
    logic [5:0]         seconds_out_reg, seconds_out_next;
    logic [6:0]         frames_out_reg, frames_out_next;
    logic               tc_ok;
    base_t              f_base;

    always_comb begin
        f_base           = s6_side_reg.e.d.base;
        tc_ok            = !f_base.kind && (rate_reg != 7'd0);
        fc_out_next      = f_base.kind ? f_base.fcres : '0;
        hours_out_next   = tc_ok ? s6_hours_reg : '0;
        minutes_out_next = tc_ok ? s6_side_reg.minutes : '0;
        seconds_out_next = tc_ok ? s6_side_reg.e.seconds : '0;
        frames_out_next  = tc_ok ? s6_side_reg.e.d.frames : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fc_out_reg      <= fc_out_next;
            hours_out_reg   <= hours_out_next;
            minutes_out_reg <= minutes_out_next;
            seconds_out_reg <= seconds_out_next;
            frames_out_reg  <= frames_out_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_frame_count_out = fc_out_reg;
    assign m_hours_out       = hours_out_reg;
    assign m_minutes_out     = minutes_out_reg;
    assign m_seconds_out     = seconds_out_reg;
    assign m_frames_out      = frames_out_reg;

    // input side only backs up when the output slot is held
    `ASSERT_IMPL(a_stall_src, aclk, aresetn, !s_ready, m_valid_reg && !m_ready, "input stalled while output free")
    // a result carries either a frame count or a timecode, never both
    `ASSERT_IMPL(a_one_dir, aclk, aresetn, m_valid_reg && (fc_out_reg != '0), (hours_out_reg == '0) && (minutes_out_reg == '0) && (seconds_out_reg == '0) && (frames_out_reg == '0), "both directions in one result")
    // hours, minutes and seconds stay inside their clock ranges
    `ASSERT_AT(a_tc_range, aclk, aresetn, !m_valid_reg || ((hours_out_reg < 5'd24) && (minutes_out_reg < 6'd60) && (seconds_out_reg < 6'd60)), "timecode field out of range")

endmodule

`default_nettype wire
